// File: rtl/glo_pkg.sv
// shared types and constants for the grid line odometer
package glo_pkg;

  // register index inside the configuration map (byte address / 4)
  typedef enum logic [2:0] {
    REG_SLOW_SPEED  = 3'd0,
    REG_FAST_SPEED  = 3'd1,
    REG_SENSE_START = 3'd2,
    REG_DEAD_LIMIT  = 3'd3,
    REG_FAST_LENGTH = 3'd4
  } reg_index_t;

  // heading encoding
  typedef enum logic [1:0] {
    HEAD_POS_X = 2'd0,
    HEAD_POS_Y = 2'd1,
    HEAD_NEG_X = 2'd2,
    HEAD_NEG_Y = 2'd3
  } heading_t;

  // item command codes
  localparam logic CMD_MOVE   = 1'b0;
  localparam logic CMD_ROTATE = 1'b1;

  // configuration port
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned LEN_BITS  = 16;

  // reset values of the configuration registers
  localparam logic [LEN_BITS-1:0] SENSE_START_RST = 16'd300;
  localparam logic [LEN_BITS-1:0] DEAD_LIMIT_RST  = 16'd460;
  localparam logic [LEN_BITS-1:0] FAST_LENGTH_RST = 16'd400;

  // sensor patterns
  localparam logic [3:0] SENS_ALL_BLACK = 4'hF;
  localparam logic [3:0] SENS_PAIR_A    = 4'h5;
  localparam logic [3:0] SENS_PAIR_B    = 4'hA;

  // distance thresholds, 16 bits unsigned
  typedef struct packed {
    logic [LEN_BITS-1:0] sense_start;
    logic [LEN_BITS-1:0] dead_limit;
    logic [LEN_BITS-1:0] fast_length;
  } dist_cfg_t;

endpackage

// File: rtl/glo_cfg_regs.sv
// configuration register bank behind the apb-style port
module glo_cfg_regs #(
  parameter int unsigned VEL_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [glo_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [glo_pkg::DATA_BITS-1:0]     pwdata,
  output logic [glo_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  output logic signed [VEL_BITS-1:0]        slow_speed,
  output logic signed [VEL_BITS-1:0]        fast_speed,
  output glo_pkg::dist_cfg_t                dist_cfg
);

  localparam logic signed [VEL_BITS-1:0] SLOW_RST = VEL_BITS'(100);
  localparam logic signed [VEL_BITS-1:0] FAST_RST = VEL_BITS'(300);

  glo_pkg::reg_index_t reg_sel;
  logic                wr_en;

  assign reg_sel = glo_pkg::reg_index_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_speed           <= SLOW_RST;
      fast_speed           <= FAST_RST;
      dist_cfg.sense_start <= glo_pkg::SENSE_START_RST;
      dist_cfg.dead_limit  <= glo_pkg::DEAD_LIMIT_RST;
      dist_cfg.fast_length <= glo_pkg::FAST_LENGTH_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        glo_pkg::REG_SLOW_SPEED:  slow_speed           <= pwdata[VEL_BITS-1:0];
        glo_pkg::REG_FAST_SPEED:  fast_speed           <= pwdata[VEL_BITS-1:0];
        glo_pkg::REG_SENSE_START: dist_cfg.sense_start <= pwdata[glo_pkg::LEN_BITS-1:0];
        glo_pkg::REG_DEAD_LIMIT:  dist_cfg.dead_limit  <= pwdata[glo_pkg::LEN_BITS-1:0];
        glo_pkg::REG_FAST_LENGTH: dist_cfg.fast_length <= pwdata[glo_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux, speeds sign extended
  always_comb begin
    unique case (reg_sel)
      glo_pkg::REG_SLOW_SPEED:  prdata = glo_pkg::DATA_BITS'(slow_speed);
      glo_pkg::REG_FAST_SPEED:  prdata = glo_pkg::DATA_BITS'(fast_speed);
      glo_pkg::REG_SENSE_START: prdata = glo_pkg::DATA_BITS'(dist_cfg.sense_start);
      glo_pkg::REG_DEAD_LIMIT:  prdata = glo_pkg::DATA_BITS'(dist_cfg.dead_limit);
      glo_pkg::REG_FAST_LENGTH: prdata = glo_pkg::DATA_BITS'(dist_cfg.fast_length);
      default:                  prdata = '0;
    endcase
  end

endmodule

// File: rtl/glo_div20.sv
// signed divide by twenty, truncating toward zero, by reciprocal multiply
module glo_div20 #(
  parameter int unsigned VEL_BITS = 12
) (
  input  logic signed [VEL_BITS-1:0] velocity,
  output logic signed [VEL_BITS-1:0] quotient
);

  // divide magnitude by 4 with a shift, then by 5 with a reciprocal
  localparam int unsigned XW = VEL_BITS - 2;
  localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / 64'd5);

  logic              neg;
  logic [VEL_BITS-1:0] mag;
  logic [XW-1:0]     x;
  logic [2*XW-1:0]   prod;
  logic [XW-1:0]     q_est;
  logic [XW+2:0]     rem;
  logic [XW-1:0]     q_fix;

  always_comb begin
    neg   = velocity[VEL_BITS-1];
    mag   = neg ? (~velocity + 1'b1) : velocity;
    x     = mag[VEL_BITS-1:2];
    prod  = x * RECIP;
    // estimate is at most one short of the true quotient
    q_est = prod[2*XW-1:XW];
    rem   = (XW+3)'(x) - (((XW+3)'(q_est)) << 2) - (XW+3)'(q_est);
    q_fix = (rem >= (XW+3)'(5)) ? (q_est + 1'b1) : q_est;
    quotient = neg ? -(VEL_BITS'(q_fix)) : VEL_BITS'(q_fix);
  end

endmodule

// File: rtl/glo_tracker.sv
// distance accumulator, line latch and cell position state with result register
module glo_tracker #(
  parameter int unsigned VEL_BITS = 12,
  parameter int unsigned ACC_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       command,
  input  logic signed [VEL_BITS-1:0] velocity,
  input  logic signed [VEL_BITS-1:0] quotient,
  input  logic [3:0]                 sensors_black,
  input  logic                       rotating,
  input  logic                       fetching,
  input  logic                       turn_clockwise,
  input  logic signed [VEL_BITS-1:0] slow_speed,
  input  logic signed [VEL_BITS-1:0] fast_speed,
  input  glo_pkg::dist_cfg_t         dist_cfg,
  output logic signed [7:0]          grid_x,
  output logic signed [7:0]          grid_y,
  output logic [1:0]                 heading,
  output logic                       cell_stepped,
  output logic                       beeper_on,
  output logic                       indicator
);

  localparam int unsigned SW = ((ACC_BITS > VEL_BITS) ? ACC_BITS : VEL_BITS) + 1;
  localparam int unsigned CW = ((ACC_BITS > glo_pkg::LEN_BITS) ?
                                ACC_BITS : glo_pkg::LEN_BITS) + 1;
  localparam logic signed [SW-1:0] ACC_MAX =
    {{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

  logic signed [ACC_BITS-1:0] distance_acc, distance_acc_next;
  logic                       line_armed, line_armed_next;
  logic signed [7:0]          pos_x, pos_x_next;
  logic signed [7:0]          pos_y, pos_y_next;
  glo_pkg::heading_t          heading_reg, heading_reg_next;
  logic                       beep_reg, beep_reg_next;
  logic                       led_reg, led_reg_next;
  logic                       stepped, stepped_next;

  logic signed [SW-1:0]       sum;
  logic signed [ACC_BITS-1:0] acc_sat;
  logic signed [ACC_BITS-1:0] acc_upd;
  logic signed [CW-1:0]       acc_cmp;
  logic signed [CW-1:0]       dead_cmp, start_cmp, len_cmp;
  logic                       slow_mode, fast_mode;
  logic                       ge_dead, ge_start, ge_len;
  logic                       armed_mid, white_pair, fire;
  logic signed [7:0]          delta;

  // saturating accumulate
  always_comb begin
    sum = {{(SW-ACC_BITS){distance_acc[ACC_BITS-1]}}, distance_acc}
        + {{(SW-VEL_BITS){quotient[VEL_BITS-1]}}, quotient};
    if (sum > ACC_MAX) begin
      acc_sat = ACC_MAX[ACC_BITS-1:0];
    end else if (sum < ACC_MIN) begin
      acc_sat = ACC_MIN[ACC_BITS-1:0];
    end else begin
      acc_sat = sum[ACC_BITS-1:0];
    end
    acc_upd = (!rotating && !fetching) ? acc_sat : distance_acc;
  end

  // threshold compares and mode select
  always_comb begin
    acc_cmp   = {{(CW-ACC_BITS){acc_upd[ACC_BITS-1]}}, acc_upd};
    dead_cmp  = {{(CW-glo_pkg::LEN_BITS){1'b0}}, dist_cfg.dead_limit};
    start_cmp = {{(CW-glo_pkg::LEN_BITS){1'b0}}, dist_cfg.sense_start};
    len_cmp   = {{(CW-glo_pkg::LEN_BITS){1'b0}}, dist_cfg.fast_length};
    ge_dead   = acc_cmp >= dead_cmp;
    ge_start  = acc_cmp >= start_cmp;
    ge_len    = acc_cmp >= len_cmp;
    slow_mode = velocity <= slow_speed;
    fast_mode = velocity == fast_speed;
    white_pair = ((sensors_black & glo_pkg::SENS_PAIR_A) == 4'h0) ||
                 ((sensors_black & glo_pkg::SENS_PAIR_B) == 4'h0);
    armed_mid = line_armed || (sensors_black == glo_pkg::SENS_ALL_BLACK);
    delta     = velocity[VEL_BITS-1] ? 8'shFF : 8'sh01;
  end

  // next state of the odometer
  always_comb begin
    distance_acc_next = distance_acc;
    line_armed_next   = line_armed;
    pos_x_next        = pos_x;
    pos_y_next        = pos_y;
    heading_reg_next  = heading_reg;
    beep_reg_next     = beep_reg;
    led_reg_next      = led_reg;
    fire              = 1'b0;
    if (command == glo_pkg::CMD_ROTATE) begin
      heading_reg_next  = glo_pkg::heading_t'(turn_clockwise ?
                          (heading_reg + 2'd1) : (heading_reg - 2'd1));
      distance_acc_next = '0;
      led_reg_next      = 1'b1;
    end else begin
      distance_acc_next = acc_upd;
      if (slow_mode) begin
        if (ge_dead) begin
          // forced step by dead reckoning
          fire              = 1'b1;
          distance_acc_next = '0;
          line_armed_next   = 1'b0;
          led_reg_next      = ~led_reg;
        end else if (ge_start) begin
          if (rotating) begin
            line_armed_next = 1'b0;
          end else if (!fetching) begin
            if (!line_armed && (sensors_black == glo_pkg::SENS_ALL_BLACK)) begin
              beep_reg_next = 1'b0;
            end
            line_armed_next = armed_mid;
            if (armed_mid && white_pair) begin
              // line crossing seen
              beep_reg_next     = 1'b1;
              fire              = 1'b1;
              distance_acc_next = '0;
              line_armed_next   = 1'b0;
              led_reg_next      = ~led_reg;
            end
          end
        end
      end else if (fast_mode && ge_len) begin
        fire              = 1'b1;
        distance_acc_next = '0;
      end
    end
    stepped_next = fire && (velocity != '0);
    if (stepped_next) begin
      unique case (heading_reg)
        glo_pkg::HEAD_POS_X: pos_x_next = pos_x + delta;
        glo_pkg::HEAD_POS_Y: pos_y_next = pos_y + delta;
        glo_pkg::HEAD_NEG_X: pos_x_next = pos_x - delta;
        glo_pkg::HEAD_NEG_Y: pos_y_next = pos_y - delta;
        default: ;
      endcase
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_acc <= '0;
      line_armed   <= 1'b0;
      pos_x        <= '0;
      pos_y        <= '0;
      heading_reg  <= glo_pkg::HEAD_POS_X;
      beep_reg     <= 1'b0;
      led_reg      <= 1'b1;
      stepped      <= 1'b0;
    end else if (advance) begin
      distance_acc <= distance_acc_next;
      line_armed   <= line_armed_next;
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      heading_reg  <= heading_reg_next;
      beep_reg     <= beep_reg_next;
      led_reg      <= led_reg_next;
      stepped      <= stepped_next;
    end
  end

  assign grid_x       = pos_x;
  assign grid_y       = pos_y;
  assign heading      = heading_reg;
  assign cell_stepped = stepped;
  assign beeper_on    = beep_reg;
  assign indicator    = led_reg;

endmodule

// File: rtl/grid_line_odometer_core.sv
// grid line odometer: input register, divide and state update in one pass, result register
// a result beat passes the input register, then the result register; throughput: one item
// per cycle while out_stall is low; the divide by twenty and the state update share one
// combinational pass, and a stalled result holds the input register in the same cycle
// reset (synchronous, active high): pipeline empty, position and heading zero,
// distance and latch cleared, beeper off, indicator on, registers at defaults
module grid_line_odometer_core #(
  parameter int unsigned VEL_BITS = 12,
  parameter int unsigned ACC_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic signed [VEL_BITS-1:0]    velocity,
  input  logic [3:0]                    sensors_black,
  input  logic                          rotating,
  input  logic                          fetching,
  input  logic                          turn_clockwise,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [7:0]             grid_x,
  output logic signed [7:0]             grid_y,
  output logic [1:0]                    heading,
  output logic                          cell_stepped,
  output logic                          beeper_on,
  output logic                          indicator,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [glo_pkg::ADDR_BITS-1:0] paddr,
  input  logic [glo_pkg::DATA_BITS-1:0] pwdata,
  output logic [glo_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  logic signed [VEL_BITS-1:0] slow_speed, fast_speed;
  glo_pkg::dist_cfg_t         dist_cfg;

  // input stage registers
  logic                       in_v;
  logic                       in_cmd;
  logic signed [VEL_BITS-1:0] in_vel;
  logic [3:0]                 in_sens;
  logic                       in_rot, in_fet, in_cw;

  logic                       res_v;
  logic signed [VEL_BITS-1:0] quo;
  logic                       res_ready, in_ready, advance;

  glo_cfg_regs #(.VEL_BITS(VEL_BITS)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slow_speed (slow_speed),
    .fast_speed (fast_speed),
    .dist_cfg   (dist_cfg)
  );

  // stage hand-off, each stage moves when the next one has room
  assign res_ready = !res_v || !out_stall;
  assign in_ready  = !in_v || res_ready;
  assign advance   = in_v && res_ready;
  assign in_stall  = !in_ready;
  assign out_valid = res_v;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      res_v <= 1'b0;
    end else begin
      if (in_ready)  in_v  <= in_valid;
      if (res_ready) res_v <= in_v;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_cmd  <= command;
      in_vel  <= velocity;
      in_sens <= sensors_black;
      in_rot  <= rotating;
      in_fet  <= fetching;
      in_cw   <= turn_clockwise;
    end
  end

  glo_div20 #(.VEL_BITS(VEL_BITS)) u_div (
    .velocity (in_vel),
    .quotient (quo)
  );

  glo_tracker #(.VEL_BITS(VEL_BITS), .ACC_BITS(ACC_BITS)) u_track (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .command        (in_cmd),
    .velocity       (in_vel),
    .quotient       (quo),
    .sensors_black  (in_sens),
    .rotating       (in_rot),
    .fetching       (in_fet),
    .turn_clockwise (in_cw),
    .slow_speed     (slow_speed),
    .fast_speed     (fast_speed),
    .dist_cfg       (dist_cfg),
    .grid_x         (grid_x),
    .grid_y         (grid_y),
    .heading        (heading),
    .cell_stepped   (cell_stepped),
    .beeper_on      (beeper_on),
    .indicator      (indicator)
  );

endmodule

// File: tb/grid_line_odometer_core_tb.sv
// testbench for the grid line odometer core: directed and random ticks against a predictor
module grid_line_odometer_core_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_DEPTH  = 2;
  localparam int IDLE_PCT    = 17;
  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  // one input beat
  typedef struct {
    logic               cmd;
    logic signed [11:0] vel;
    logic [3:0]         sens;
    logic               rot;
    logic               fet;
    logic               cw;
  } tick_t;

  // one result beat
  typedef struct {
    logic [7:0] gx;
    logic [7:0] gy;
    logic [1:0] hd;
    logic       stepped;
    logic       beep;
    logic       led;
  } position_t;

  // block ports
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          command = glo_pkg::CMD_MOVE;
  logic signed [11:0]            velocity = '0;
  logic [3:0]                    sensors_black = '0;
  logic                          rotating = 1'b0;
  logic                          fetching = 1'b0;
  logic                          turn_clockwise = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [7:0]             grid_x;
  logic signed [7:0]             grid_y;
  logic [1:0]                    heading;
  logic                          cell_stepped;
  logic                          beeper_on;
  logic                          indicator;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [glo_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [glo_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [glo_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  // predicted odometer state
  longint     dist_acc = 0;
  bit         latch_armed = 1'b0;
  logic [7:0] cell_x = '0;
  logic [7:0] cell_y = '0;
  logic [1:0] head_dir = glo_pkg::HEAD_POS_X;
  bit         beep_lvl = 1'b0;
  bit         led_lvl = 1'b1;

  // predicted register contents
  logic signed [11:0] slow_cfg  = 12'sd100;
  logic signed [11:0] fast_cfg  = 12'sd300;
  logic [15:0]        start_cfg = glo_pkg::SENSE_START_RST;
  logic [15:0]        limit_cfg = glo_pkg::DEAD_LIMIT_RST;
  logic [15:0]        len_cfg   = glo_pkg::FAST_LENGTH_RST;

  position_t pending_positions[$];
  bit        idle_on = 1'b1;
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        step_count = 0;
  int        turn_count = 0;
  int        config_count = 0;
  int        cycle_count = 0;

  always #5 clk = ~clk;

  grid_line_odometer_core DUT (.*);

  // one cell along the heading, direction from the velocity sign
  function automatic bit move_one_cell(longint v);
    logic [7:0] d;
    if (v == 0) return 1'b0;
    d = (v > 0) ? 8'd1 : 8'hFF;
    case (head_dir)
      glo_pkg::HEAD_POS_X: cell_x = cell_x + d;
      glo_pkg::HEAD_POS_Y: cell_y = cell_y + d;
      glo_pkg::HEAD_NEG_X: cell_x = cell_x - d;
      default:             cell_y = cell_y - d;
    endcase
    return 1'b1;
  endfunction

  // advance the odometer by one tick and return the resulting position beat
  function automatic position_t advance_odometer(tick_t t);
    position_t r;
    longint    v;
    bit        moved;
    bit        white;
    moved = 1'b0;
    if (t.cmd == glo_pkg::CMD_ROTATE) begin
      head_dir = t.cw ? head_dir + 2'd1 : head_dir - 2'd1;
      dist_acc = 0;
      led_lvl  = 1'b1;
      turn_count++;
    end else begin
      v = t.vel;
      if (!t.rot && !t.fet) begin
        dist_acc = dist_acc + v / 20;
        if (dist_acc > ACC_MAX) dist_acc = ACC_MAX;
        else if (dist_acc < ACC_MIN) dist_acc = ACC_MIN;
      end
      white = ((t.sens & glo_pkg::SENS_PAIR_A) == 4'h0) ||
              ((t.sens & glo_pkg::SENS_PAIR_B) == 4'h0);
      if (v <= longint'(slow_cfg)) begin
        // line sensing mode: forced step first, then the latch inside the window
        if (dist_acc >= longint'(limit_cfg)) begin
          moved       = move_one_cell(v);
          dist_acc    = 0;
          latch_armed = 1'b0;
          led_lvl     = ~led_lvl;
        end else if (dist_acc >= longint'(start_cfg)) begin
          if (t.rot) begin
            latch_armed = 1'b0;
          end else if (!t.fet) begin
            if (!latch_armed && t.sens == glo_pkg::SENS_ALL_BLACK) begin
              beep_lvl    = 1'b0;
              latch_armed = 1'b1;
            end
            if (latch_armed && white) begin
              beep_lvl    = 1'b1;
              moved       = move_one_cell(v);
              dist_acc    = 0;
              latch_armed = 1'b0;
              led_lvl     = ~led_lvl;
            end
          end
        end
      end else if (v == longint'(fast_cfg)) begin
        // pure distance count
        if (dist_acc >= longint'(len_cfg)) begin
          dist_acc = 0;
          moved    = move_one_cell(v);
        end
      end
    end
    if (moved) step_count++;
    r.gx      = cell_x;
    r.gy      = cell_y;
    r.hd      = head_dir;
    r.stepped = moved;
    r.beep    = beep_lvl;
    r.led     = led_lvl;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("result %0d: %s", results_checked, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // result checking and input capture, both on the rising edge
  always @(posedge clk) begin
    position_t want;
    tick_t     t;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_positions.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = pending_positions.pop_front();
          check_field("grid_x", grid_x, want.gx);
          check_field("grid_y", grid_y, want.gy);
          check_field("heading", {6'd0, heading}, {6'd0, want.hd});
          check_field("cell_stepped", {7'd0, cell_stepped}, {7'd0, want.stepped});
          check_field("beeper_on", {7'd0, beeper_on}, {7'd0, want.beep});
          check_field("indicator", {7'd0, indicator}, {7'd0, want.led});
        end
        results_checked++;
      end
      if (in_valid && !in_stall) begin
        t.cmd  = command;
        t.vel  = velocity;
        t.sens = sensors_black;
        t.rot  = rotating;
        t.fet  = fetching;
        t.cw   = turn_clockwise;
        pending_positions.push_back(advance_odometer(t));
        items_sent++;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_positions.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) out_stall = idle_on && ($urandom_range(99) < IDLE_PCT);

  // send one tick beat and wait for it to be taken
  task automatic send_tick(tick_t t);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    command        = t.cmd;
    velocity       = t.vel;
    sensors_black  = t.sens;
    rotating       = t.rot;
    fetching       = t.fet;
    turn_clockwise = t.cw;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic move(int v, logic [3:0] s, logic rot_b, logic fet_b);
    tick_t t;
    t.cmd  = glo_pkg::CMD_MOVE;
    t.vel  = v[11:0];
    t.sens = s;
    t.rot  = rot_b;
    t.fet  = fet_b;
    t.cw   = 1'($urandom_range(1));
    send_tick(t);
  endtask

  // rotate beat with junk in the fields it ignores
  task automatic turn(logic cw_b);
    tick_t t;
    t.cmd  = glo_pkg::CMD_ROTATE;
    t.vel  = 12'($urandom);
    t.sens = 4'($urandom);
    t.rot  = 1'($urandom_range(1));
    t.fet  = 1'($urandom_range(1));
    t.cw   = cw_b;
    send_tick(t);
  endtask

  // random tick biased toward the active modes and toward arm-then-cross sequences
  function automatic tick_t random_tick();
    tick_t      t;
    int         v;
    int         pick;
    logic [3:0] w;
    t.cmd = ($urandom_range(99) < 8) ? glo_pkg::CMD_ROTATE : glo_pkg::CMD_MOVE;
    t.cw  = 1'($urandom_range(1));
    t.rot = ($urandom_range(99) < 8);
    t.fet = ($urandom_range(99) < 8);
    pick  = int'($urandom_range(99));
    if (pick < 30) v = int'(fast_cfg);
    else if (pick < 70) v = int'(slow_cfg) - int'($urandom_range(60));
    else if (pick < 80) v = int'($urandom_range(38)) - 19;
    else if (pick < 88) v = -int'($urandom_range(2048));
    else v = int'($urandom_range(4095)) - 2048;
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    t.vel = v[11:0];
    pick  = int'($urandom_range(99));
    w     = 4'($urandom_range(15));
    if (!latch_armed && pick < 45) t.sens = glo_pkg::SENS_ALL_BLACK;
    else if (latch_armed && pick < 50)
      t.sens = $urandom_range(1) ? (w & ~glo_pkg::SENS_PAIR_A) : (w & ~glo_pkg::SENS_PAIR_B);
    else t.sens = w;
    return t;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_tick(random_tick());
  endtask

  // hold the sender until every pending result is back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      glo_pkg::REG_SLOW_SPEED:  slow_cfg  = val[11:0];
      glo_pkg::REG_FAST_SPEED:  fast_cfg  = val[11:0];
      glo_pkg::REG_SENSE_START: start_cfg = val[15:0];
      glo_pkg::REG_DEAD_LIMIT:  limit_cfg = val[15:0];
      glo_pkg::REG_FAST_LENGTH: len_cfg   = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(int slow, int fast, int start, int limit, int len);
    wait_drained();
    write_reg(glo_pkg::REG_SLOW_SPEED, slow);
    write_reg(glo_pkg::REG_FAST_SPEED, fast);
    write_reg(glo_pkg::REG_SENSE_START, start);
    write_reg(glo_pkg::REG_DEAD_LIMIT, limit);
    write_reg(glo_pkg::REG_FAST_LENGTH, len);
    config_count++;
  endtask

  // heading wraps both ways
  task automatic test_turns();
    turn(1'b1);
    turn(1'b0);
    turn(1'b0);
    turn(1'b1);
  endtask

  // busy ticks, reversing, fast count step and a speed in neither mode
  task automatic test_fast_mode();
    set_config(100, 300, 10, 30, 20);
    move(2047, 4'h0, 1'b1, 1'b1);
    move(-2048, glo_pkg::SENS_ALL_BLACK, 1'b0, 1'b0);
    turn(1'b1);
    move(300, 4'h0, 1'b0, 1'b0);
    move(300, 4'h0, 1'b0, 1'b0);
    move(150, glo_pkg::SENS_ALL_BLACK, 1'b0, 1'b0);
  endtask

  // arm, clear by rotation, re-arm, hold while fetching, cross on a white pair
  task automatic test_line_latch();
    move(100, 4'h0, 1'b0, 1'b0);
    move(100, glo_pkg::SENS_ALL_BLACK, 1'b0, 1'b0);
    move(100, 4'h0, 1'b1, 1'b0);
    move(100, glo_pkg::SENS_ALL_BLACK, 1'b0, 1'b0);
    move(100, 4'h0, 1'b0, 1'b1);
    move(100, glo_pkg::SENS_PAIR_A, 1'b0, 1'b0);
  endtask

  // forced step at the limit, then a crossing at zero velocity
  task automatic test_forced_and_zero();
    repeat (6) move(100, 4'h0, 1'b0, 1'b0);
    move(100, 4'h0, 1'b0, 1'b0);
    move(100, glo_pkg::SENS_ALL_BLACK, 1'b0, 1'b0);
    move(0, 4'h0, 1'b0, 1'b0);
  endtask

  // unmapped indexes are dropped, upper data bits are ignored
  task automatic test_register_decode();
    wait_drained();
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    write_reg(glo_pkg::REG_SLOW_SPEED, 32'hFFFF_F190);
    write_reg(glo_pkg::REG_FAST_SPEED, 32'h7FFF_F258);
    write_reg(glo_pkg::REG_SENSE_START, 32'hABCD_0014);
    write_reg(glo_pkg::REG_DEAD_LIMIT, 32'hFFFF_003C);
    write_reg(glo_pkg::REG_FAST_LENGTH, 32'h8000_0028);
    config_count++;
    run_random(40);
  endtask

  task automatic test_random_small_cells();
    set_config(400, 600, 20, 60, 40);
    run_random(220);
  endtask

  task automatic test_random_extremes();
    set_config(2047, -2048, 0, 65535, 0);
    run_random(100);
    set_config(-2048, 2047, 65535, 0, 65535);
    run_random(100);
    set_config(0, -1, 0, 1, 1);
    run_random(100);
  endtask

  task automatic test_random_defaults();
    set_config(100, 300, 300, 460, 400);
    run_random(250);
  endtask

  // sender holds off mid-phase until the pipeline is empty
  task automatic test_drain_pause();
    set_config(300, 500, 30, 80, 50);
    run_random(60);
    wait_drained();
    run_random(60);
  endtask

  // back-to-back beats with no stall on either side
  task automatic test_random_no_idle();
    set_config(150, 400, 40, 90, 60);
    idle_on = 1'b0;
    run_random(250);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_turns();
    test_fast_mode();
    test_line_latch();
    test_forced_and_zero();
    test_register_decode();
    test_random_small_cells();
    test_random_extremes();
    test_random_defaults();
    test_drain_pause();
    test_random_no_idle();
    wait_drained();
    repeat (10) @(negedge clk);
    $display("covered %0d ticks and %0d result beats over %0d register settings",
             items_sent, results_checked, config_count);
    $display("predicted %0d cell steps and %0d rotations, %0d mismatches",
             step_count, turn_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
